>>> src/bounded_deque_with_value_delete_unit_macros.svh
// Assertion macros shared by the deque unit.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bdq_pkg.sv
// Shared constants, operation codes and cell command type of the deque unit.
package bdq_pkg;
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int OP_W           = 4;
	localparam int VAL_W          = 32;
	localparam int CNT_IN_W       = 7;
	localparam int STAT_W         = 2;
	localparam int CMP_W          = 8;

	localparam logic [OP_W-1:0] OP_ADD_BACK    = 4'd0;
	localparam logic [OP_W-1:0] OP_ADD_FRONT   = 4'd1;
	localparam logic [OP_W-1:0] OP_RM_FRONT    = 4'd2;
	localparam logic [OP_W-1:0] OP_RM_BACK     = 4'd3;
	localparam logic [OP_W-1:0] OP_CLEAR       = 4'd4;
	localparam logic [OP_W-1:0] OP_RM_VALUE    = 4'd5;
	localparam logic [OP_W-1:0] OP_PRINT_ALL   = 4'd6;
	localparam logic [OP_W-1:0] OP_PRINT_FIRST = 4'd7;
	localparam logic [OP_W-1:0] OP_PRINT_LAST  = 4'd8;

	localparam logic [STAT_W-1:0] STAT_ELEM  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	localparam logic [2:0] CELL_HOLD = 3'd0;
	localparam logic [2:0] CELL_SHL  = 3'd1;
	localparam logic [2:0] CELL_SHR  = 3'd2;
	localparam logic [2:0] CELL_ROT  = 3'd3;
	localparam logic [2:0] CELL_PUT  = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic       keep;
	} cell_cmd_t;
endpackage

>>> src/bdq_cell.sv
// One storage cell of the deque row, exchanging its element with its neighbors.
module bdq_cell import bdq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int IDX_W      = 6,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [IDX_W-1:0]      tail,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic [DATA_WIDTH-1:0] head,
	output logic [DATA_WIDTH-1:0] q
);
	logic [DATA_WIDTH-1:0] d_q;
	logic                  at_tail;

	assign at_tail = (tail == IDX_W'(CELL_IDX));
	assign q       = d_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SHL: begin
				d_q <= right;
			end
			CELL_SHR: begin
				d_q <= left;
			end
			CELL_ROT: begin
				if (cmd.keep && at_tail) begin
					d_q <= head;
				end else begin
					d_q <= right;
				end
			end
			CELL_PUT: begin
				if (at_tail) begin
					d_q <= din;
				end
			end
			default: begin
				d_q <= d_q;
			end
		endcase
	end
endmodule

>>> src/bdq_ctrl.sv
// Sequencer of the deque: decodes requests, drives the cell row and holds the result register.
`include "bounded_deque_with_value_delete_unit_macros.svh"
module bdq_ctrl import bdq_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [CNT_IN_W-1:0]   count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STAT_W-1:0]     status,
	output logic [DATA_WIDTH-1:0] element,
	output logic                  last_of_run,
	input  logic [DATA_WIDTH-1:0] head,
	output cell_cmd_t             cmd,
	output logic [IDX_W-1:0]      tail,
	output logic [DATA_WIDTH-1:0] din
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic                  state_q;
	logic                  rm_mode_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      k_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [DATA_WIDTH-1:0] element_q;
	logic                  last_q;

	logic                  accept;
	logic                  out_free;
	logic                  full;
	logic                  empty;
	logic [CMP_W-1:0]      cnt_x;
	logic [CMP_W-1:0]      cin_x;
	logic [CNT_W-1:0]      n_sel;
	logic [CNT_W-1:0]      cnt_m1;
	logic                  in_win;
	logic                  step;
	logic                  keep;
	logic                  last_step;
	logic                  add_op;
	logic                  print_op;
	logic                  load_out;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign cnt_x     = CMP_W'(cnt_q);
	assign cin_x     = CMP_W'(count);
	assign n_sel     = (cin_x < cnt_x) ? cin_x[CNT_W-1:0] : cnt_q;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign in_win    = (k_q >= lo_q) && (k_q < hi_q);
	assign step      = (state_q == S_RUN) && (rm_mode_q || !in_win || out_free);
	assign keep      = rm_mode_q ? (head != val_q) : 1'b1;
	assign last_step = (k_q == total_q - CNT_W'(1));
	assign add_op    = (op == OP_ADD_BACK) || (op == OP_ADD_FRONT);
	assign print_op  = (op == OP_PRINT_ALL) || (op == OP_PRINT_FIRST) || (op == OP_PRINT_LAST);
	assign load_out  = (accept && ((add_op && full) ||
		(print_op && (empty || (op != OP_PRINT_ALL && count == '0))))) ||
		(step && !rm_mode_q && in_win);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign element     = element_q;
	assign last_of_run = last_q;

	always_comb begin
		cmd.op   = CELL_HOLD;
		cmd.keep = 1'b0;
		tail     = cnt_q[IDX_W-1:0];
		din      = value;
		if (accept) begin
			case (op)
				OP_ADD_BACK: begin
					if (!full) begin
						cmd.op = CELL_PUT;
					end
				end
				OP_ADD_FRONT: begin
					if (!full) begin
						cmd.op = CELL_SHR;
					end
				end
				OP_RM_FRONT: begin
					if (!empty) begin
						cmd.op = CELL_SHL;
					end
				end
				default: begin
					cmd.op = CELL_HOLD;
				end
			endcase
		end else if (step) begin
			cmd.op   = CELL_ROT;
			cmd.keep = keep;
			tail     = cnt_m1[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rm_mode_q   <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			total_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				k_q     <= '0;
				total_q <= cnt_q;
				case (op)
					OP_ADD_BACK, OP_ADD_FRONT: begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					OP_RM_FRONT, OP_RM_BACK: begin
						if (!empty) begin
							cnt_q <= cnt_m1;
						end
					end
					OP_CLEAR: begin
						cnt_q <= '0;
					end
					OP_RM_VALUE: begin
						if (!empty) begin
							state_q   <= S_RUN;
							rm_mode_q <= 1'b1;
							lo_q      <= '0;
							hi_q      <= '0;
						end
					end
					OP_PRINT_ALL, OP_PRINT_FIRST, OP_PRINT_LAST: begin
						if (!empty && (op == OP_PRINT_ALL || count != '0)) begin
							state_q   <= S_RUN;
							rm_mode_q <= 1'b0;
							if (op == OP_PRINT_ALL) begin
								lo_q <= '0;
								hi_q <= cnt_q;
							end else if (op == OP_PRINT_FIRST) begin
								lo_q <= '0;
								hi_q <= n_sel;
							end else begin
								lo_q <= cnt_q - n_sel;
								hi_q <= cnt_q;
							end
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end else if (step) begin
				k_q <= k_q + CNT_W'(1);
				if (rm_mode_q && !keep) begin
					cnt_q <= cnt_m1;
				end
				if (last_step) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= value;
			element_q <= '0;
			last_q    <= 1'b1;
			if (op == OP_ADD_BACK || op == OP_ADD_FRONT) begin
				status_q <= STAT_FULL;
			end else if (empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_NONE;
			end
		end else if (step && !rm_mode_q && in_win) begin
			status_q  <= STAT_ELEM;
			element_q <= head;
			last_q    <= (k_q == hi_q - CNT_W'(1));
		end
	end

	`BDQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "element count above capacity")
	`BDQ_ASSERT_IMPL(a_run_nonempty, state_q == S_RUN, total_q != '0 && !in_ready, "run state with no work or open input")
	`BDQ_ASSERT_NEXT(a_rm_shrinks, state_q == S_RUN && rm_mode_q, cnt_q <= $past(cnt_q), "value removal grew the list")
	`BDQ_ASSERT_NEXT(a_print_keeps, state_q == S_RUN && !rm_mode_q, cnt_q == $past(cnt_q), "print changed the list length")
endmodule

>>> src/bounded_deque_with_value_delete_unit.sv
// Top level of the bounded deque with remove-by-value: sequencer and row of cells.
// The list lives in a row of CAPACITY cells with the front element always in the first cell.
// Add at back or front, remove at front or back, clear, and requests that only return a status
// (add to a full list, print of an empty list, print of zero elements) are done when the request
// is accepted. Remove by value and the other prints then step once per stored element: the row
// rotates by one position each cycle while the front cell is compared or sent out, but a print
// step that sends out an element waits while a result is held in the output
// register and out_ready is low. A new request is taken only when the previous one has finished
// and the output register is empty or is being read in the same cycle.
module bounded_deque_with_value_delete_unit import bdq_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic signed [VAL_W-1:0] value,
	input  logic [CNT_IN_W-1:0] count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic signed [VAL_W-1:0] element,
	output logic                last_of_run
);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [DATA_WIDTH-1:0] value_d;
	logic [DATA_WIDTH-1:0] elem_d;
	logic [DATA_WIDTH-1:0] din;
	logic [IDX_W-1:0]      tail;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] row [CAPACITY];

	if (DATA_WIDTH > VAL_W) begin : g_wide
		assign value_d = {{(DATA_WIDTH-VAL_W){1'b0}}, value};
		assign element = elem_d[VAL_W-1:0];
	end else if (DATA_WIDTH == VAL_W) begin : g_same
		assign value_d = value;
		assign element = elem_d;
	end else begin : g_narrow
		assign value_d = value[DATA_WIDTH-1:0];
		assign element = {{(VAL_W-DATA_WIDTH){1'b0}}, elem_d};
	end

	bdq_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.value      (value_d),
		.count      (count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.element    (elem_d),
		.last_of_run(last_of_run),
		.head       (row[0]),
		.cmd        (cmd),
		.tail       (tail),
		.din        (din)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = din;
		end else begin : g_mid_l
			assign left_d = row[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = row[i];
		end else begin : g_mid_r
			assign right_d = row[i+1];
		end

		bdq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.tail (tail),
			.din  (din),
			.left (left_d),
			.right(right_d),
			.head (row[0]),
			.q    (row[i])
		);
	end
endmodule
